// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the frame receiver.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/afr_pkg.sv =====
// Package for the addressed frame receiver: frame constants, command codes,
// event codes, the CRC-8 byte step and the command decode. No dependencies.
`timescale 1ns / 1ps

package afr_pkg;

  // Frame header bytes and CRC polynomial (reflected 0x31)
  localparam logic [7:0] HEAD_FIRST  = 8'h54;
  localparam logic [7:0] HEAD_SECOND = 8'h48;
  localparam logic [7:0] CRC_POLY    = 8'h8C;

  // Byte positions within a frame, counted from 1
  localparam logic [8:0] POS_HEAD_FIRST  = 9'd1;
  localparam logic [8:0] POS_HEAD_SECOND = 9'd2;
  localparam logic [8:0] POS_ADDRESS     = 9'd3;
  localparam logic [8:0] POS_COMMAND     = 9'd4;
  localparam logic [8:0] POS_LENGTH      = 9'd5;

  // Command codes
  localparam logic [7:0] CMD_TEST     = 8'd1;
  localparam logic [7:0] CMD_REPORT   = 8'd2;
  localparam logic [7:0] CMD_TIMING   = 8'd3;
  localparam logic [7:0] CMD_INTERVAL = 8'd4;
  localparam logic [7:0] CMD_REBOOT   = 8'd5;
  localparam logic [7:0] CMD_HISTORY  = 8'd6;

  // Event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_REPORT   = 3'd1;
  localparam logic [2:0] EV_TIMING   = 3'd2;
  localparam logic [2:0] EV_INTERVAL = 3'd3;
  localparam logic [2:0] EV_REBOOT   = 3'd4;
  localparam logic [2:0] EV_HISTORY  = 3'd5;

  typedef struct packed {
    logic       ack_needed;
    logic [2:0] event_code;
    logic       keep_low_half;
  } cmd_decode_t;

  // One byte through the reflected CRC-8: eight fixed shift/xor steps
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] v;
    v = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

  // Map a command byte to its ack flag, event code and low-half keep flag
  function automatic cmd_decode_t decode_cmd(input logic [7:0] cmd);
    cmd_decode_t d;
    d = '{ack_needed: 1'b0, event_code: EV_NONE, keep_low_half: 1'b0};
    unique case (cmd)
      CMD_TEST:     d.ack_needed = 1'b1;
      CMD_REPORT:   d.event_code = EV_REPORT;
      CMD_TIMING: begin
        d.ack_needed = 1'b1;
        d.event_code = EV_TIMING;
      end
      CMD_INTERVAL: begin
        d.ack_needed    = 1'b1;
        d.event_code    = EV_INTERVAL;
        d.keep_low_half = 1'b1;
      end
      CMD_REBOOT: begin
        d.ack_needed = 1'b1;
        d.event_code = EV_REBOOT;
      end
      CMD_HISTORY:  d.event_code = EV_HISTORY;
      default:      d = d;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/addressed_frame_receiver_crc8.sv =====
// Addressed frame receiver top level: input register, frame tracking, CRC
// check and result register. Depends on afr_pkg and assert_macros.svh.
// Usage: feed received bytes on the in_ channel, one request per byte; the
// block takes a byte every cycle while the result side keeps up; each byte
// passes the input register, and a good frame then the result register. A
// frame is 'T', 'H', own address, command, length L, L data bytes and a
// reflected CRC-8 (poly 0x8C, init 0) over the data. A frame whose check
// byte matches yields one result request in the cycle after its check byte
// leaves the input register; bad frames and header misses give nothing.
// The own_address register takes writes on cfg_ at any cycle (cfg_ready is
// always high) and applies from the next address byte on.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module addressed_frame_receiver_crc8 (
  input  logic        clk,
  input  logic        rst_n,
  // received bytes
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // frame results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_command,
  output logic [7:0]  out_data_length,
  output logic [31:0] out_payload_word,
  output logic        out_ack_needed,
  output logic [2:0]  out_event_code,
  // own address register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_own_address
);

  logic        in_v_r;
  logic [7:0]  byte_r;
  logic [7:0]  own_addr_r;

  logic [8:0]  pos_r, pos_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [31:0] cap_r, cap_nxt;

  logic        out_v_r;
  logic [7:0]  out_cmd_r;
  logic [7:0]  out_len_r;
  logic [31:0] out_word_r;
  logic        out_ack_r;
  logic [2:0]  out_ev_r;

  logic        out_free;
  logic        step;
  logic        produce;
  logic [8:0]  pos_inc;
  logic [8:0]  pos_check;
  logic [8:0]  data_idx;
  afr_pkg::cmd_decode_t dec;

  // Handshake: a byte leaves the input register when the result side has room
  assign out_free  = !out_v_r || !out_stall;
  assign step      = in_v_r && out_free;
  assign in_stall  = in_v_r && !out_free;
  assign cfg_ready = 1'b1;

  // Hold the own address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      own_addr_r <= cfg_own_address;
    end
  end

  // Capture incoming byte requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      byte_r <= in_rx_byte;
    end
  end

  // Advance the frame tracker on the registered byte
  assign pos_inc   = pos_r + 9'd1;
  assign pos_check = {1'b0, len_r} + afr_pkg::POS_LENGTH + 9'd1;
  assign data_idx  = pos_inc - afr_pkg::POS_LENGTH - 9'd1;
  assign dec       = afr_pkg::decode_cmd(cmd_r);

  always_comb begin
    pos_nxt = pos_inc;
    len_nxt = len_r;
    crc_nxt = crc_r;
    cmd_nxt = cmd_r;
    cap_nxt = cap_r;
    produce = 1'b0;
    priority if (pos_inc == afr_pkg::POS_HEAD_FIRST) begin
      if (byte_r != afr_pkg::HEAD_FIRST) pos_nxt = '0;
    end else if (pos_inc == afr_pkg::POS_HEAD_SECOND) begin
      if (byte_r != afr_pkg::HEAD_SECOND) pos_nxt = '0;
    end else if (pos_inc == afr_pkg::POS_ADDRESS) begin
      if (byte_r != own_addr_r) pos_nxt = '0;
    end else if (pos_inc == afr_pkg::POS_COMMAND) begin
      cmd_nxt = byte_r;
    end else if (pos_inc == afr_pkg::POS_LENGTH) begin
      len_nxt = byte_r;
      crc_nxt = '0;
      cap_nxt = '0;
    end else if (pos_inc == pos_check) begin
      produce = (byte_r == crc_r);
      pos_nxt = '0;
    end else if (pos_inc > afr_pkg::POS_LENGTH) begin
      crc_nxt = afr_pkg::crc8_step(crc_r, byte_r);
      if (data_idx < 9'd4) begin
        cap_nxt = cap_r | ({24'd0, byte_r} << {data_idx[1:0], 3'b000});
      end
    end else begin
      pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      len_r <= '0;
      crc_r <= '0;
      cmd_r <= '0;
      cap_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      crc_r <= crc_nxt;
      cmd_r <= cmd_nxt;
      cap_r <= cap_nxt;
    end
  end

  // Load a result on a good check byte, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step && produce) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && produce) begin
      out_cmd_r  <= cmd_r;
      out_len_r  <= len_r;
      out_word_r <= dec.keep_low_half ? {16'd0, cap_r[15:0]} : cap_r;
      out_ack_r  <= dec.ack_needed;
      out_ev_r   <= dec.event_code;
    end
  end

  assign out_valid         = out_v_r;
  assign out_frame_command = out_cmd_r;
  assign out_data_length   = out_len_r;
  assign out_payload_word  = out_word_r;
  assign out_ack_needed    = out_ack_r;
  assign out_event_code    = out_ev_r;

  // Checks
  `ASSERT_AT(a_result_loaded, (step && produce) |=> out_v_r, "good frame gave no result")
  `ASSERT_NEVER(a_pos_bound, (pos_r > afr_pkg::POS_LENGTH) && (pos_r > ({1'b0, len_r} + afr_pkg::POS_LENGTH)), "byte position past frame end")
  `ASSERT_NEVER(a_stall_empty, in_stall && !in_v_r, "input stalled with empty register")
  `ASSERT_AT(a_no_step_full, (out_v_r && out_stall) |-> !step, "byte consumed while result blocked")

endmodule
